@@ hdl/i2cm_pkg.sv @@
// i2cm_pkg: types, register offsets, bit positions and bus action codes
// for the i2c master register interface; no dependencies
package i2cm_pkg;

    // register byte offsets
    localparam logic [4:0] OFF_ADDR = 5'd0;
    localparam logic [4:0] OFF_FREQ = 5'd4;
    localparam logic [4:0] OFF_CTRL = 5'd8;
    localparam logic [4:0] OFF_STAT = 5'd12;
    localparam logic [4:0] OFF_DATA = 5'd16;
    localparam logic [4:0] OFF_FILT = 5'd20;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // control register bits
    localparam int CR_MEN  = 7;
    localparam int CR_MIEN = 6;
    localparam int CR_MSTA = 5;
    localparam int CR_MTX  = 4;
    localparam int CR_RSTA = 2;

    // status register bits
    localparam int SR_MBB  = 5;
    localparam int SR_MIF  = 1;
    localparam int SR_RXAK = 0;

    // masks and reset values
    localparam logic [7:0] STATUS_RESET   = 8'h81;
    localparam logic [7:0] CTRL_WR_MASK   = 8'hf9;
    localparam logic [7:0] CTRL_RD_MASK   = 8'hf9;   // reads clear bits 2 and 1
    localparam logic [7:0] STAT_WR_MASK   = 8'h12;
    localparam logic [5:0] DIV_MASK       = 6'h3f;
    localparam logic [7:0] RD_UNKNOWN     = 8'hff;
    localparam logic [7:0] BUF_EMPTY      = 8'hff;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_END  = 3'd1,
        ACT_ADDR = 3'd2,
        ACT_SEND = 3'd3,
        ACT_RECV = 3'd4
    } action_t;

    typedef struct packed {
        logic       command;
        logic [4:0] reg_offset;
        logic [7:0] write_data;
        logic       bus_ack;
        logic [7:0] bus_rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [2:0] bus_action;
        logic [7:0] bus_byte;
        logic       misuse;
    } out_item_t;

endpackage

@@ hdl/i2cm_stream_if.sv @@
// i2cm_stream_if: valid/ready channel carrying one item of a given payload type
// depends on nothing; payload types come from i2cm_pkg at instantiation
interface i2cm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/i2cm_regs.sv @@
// i2cm_regs: controller register state and the single-pass access logic
// depends on i2cm_pkg
module i2cm_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  i2cm_pkg::in_item_t  item,
    output i2cm_pkg::out_item_t result
);

    logic [7:0] control_reg, control_next;
    logic [7:0] status_reg, status_next;
    logic [5:0] freq_reg, freq_next;
    logic [5:0] filter_reg, filter_next;
    logic [7:0] rxbuf_reg, rxbuf_next;
    logic       bufvalid_reg, bufvalid_next;
    logic       open_reg, open_next;

    logic              busy;
    logic              was_msta;
    logic              now_msta;
    logic [7:0]        rd;
    i2cm_pkg::action_t act;
    logic [7:0]        byte_out;
    logic              bad;

    assign busy = control_reg[i2cm_pkg::CR_MEN] & status_reg[i2cm_pkg::SR_MBB];

    // access decode and next state
    always_comb
    begin
        control_next  = control_reg;
        status_next   = status_reg;
        freq_next     = freq_reg;
        filter_next   = filter_reg;
        rxbuf_next    = rxbuf_reg;
        bufvalid_next = bufvalid_reg;
        open_next     = open_reg;
        rd            = '0;
        act           = i2cm_pkg::ACT_NONE;
        byte_out      = '0;
        bad           = 1'b0;
        was_msta      = control_reg[i2cm_pkg::CR_MSTA];
        now_msta      = item.write_data[i2cm_pkg::CR_MSTA];

        if (item.command == i2cm_pkg::CMD_WRITE)
        begin
            case (item.reg_offset)
                i2cm_pkg::OFF_FREQ:
                begin
                    freq_next = item.write_data[5:0] & i2cm_pkg::DIV_MASK;
                end
                i2cm_pkg::OFF_CTRL:
                begin
                    // start, stop and repeated start all close the transfer
                    if (item.write_data[i2cm_pkg::CR_MEN] &&
                        ((was_msta != now_msta) ||
                         (was_msta && item.write_data[i2cm_pkg::CR_RSTA])))
                    begin
                        status_next[i2cm_pkg::SR_MBB] = now_msta;
                        act       = i2cm_pkg::ACT_END;
                        open_next = 1'b0;
                    end
                    control_next = item.write_data & i2cm_pkg::CTRL_WR_MASK;
                end
                i2cm_pkg::OFF_STAT:
                begin
                    status_next = (status_reg & ~i2cm_pkg::STAT_WR_MASK) |
                                  (item.write_data & i2cm_pkg::STAT_WR_MASK);
                end
                i2cm_pkg::OFF_DATA:
                begin
                    if (busy && !open_reg)
                    begin
                        act       = i2cm_pkg::ACT_ADDR;
                        byte_out  = item.write_data;
                        open_next = item.bus_ack;
                        status_next[i2cm_pkg::SR_MIF]  = 1'b1;
                        status_next[i2cm_pkg::SR_RXAK] = 1'b0;
                    end
                    else if (busy && control_reg[i2cm_pkg::CR_MTX])
                    begin
                        act      = i2cm_pkg::ACT_SEND;
                        byte_out = item.write_data;
                        status_next[i2cm_pkg::SR_MIF]  = 1'b1;
                        status_next[i2cm_pkg::SR_RXAK] = 1'b0;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                i2cm_pkg::OFF_FILT:
                begin
                    filter_next = item.write_data[5:0] & i2cm_pkg::DIV_MASK;
                end
                default:
                begin
                    bad = 1'b0;
                end
            endcase
        end
        else
        begin
            case (item.reg_offset)
                i2cm_pkg::OFF_ADDR: rd = '0;
                i2cm_pkg::OFF_FREQ: rd = {2'b00, freq_reg};
                i2cm_pkg::OFF_CTRL: rd = control_reg & i2cm_pkg::CTRL_RD_MASK;
                i2cm_pkg::OFF_STAT: rd = status_reg;
                i2cm_pkg::OFF_DATA:
                begin
                    // pipelined receive: hand back the old buffer, fetch the next byte
                    rd = rxbuf_reg;
                    if (busy && open_reg && !control_reg[i2cm_pkg::CR_MTX])
                    begin
                        act           = i2cm_pkg::ACT_RECV;
                        rxbuf_next    = item.bus_rx_byte;
                        bufvalid_next = 1'b1;
                        status_next[i2cm_pkg::SR_MIF]  = 1'b1;
                        status_next[i2cm_pkg::SR_RXAK] = 1'b0;
                    end
                    else
                    begin
                        bad           = !busy || !bufvalid_reg;
                        rxbuf_next    = i2cm_pkg::BUF_EMPTY;
                        bufvalid_next = 1'b0;
                    end
                end
                i2cm_pkg::OFF_FILT: rd = {2'b00, filter_reg};
                default:            rd = i2cm_pkg::RD_UNKNOWN;
            endcase
        end

        result.read_data  = rd;
        result.irq        = control_next[i2cm_pkg::CR_MIEN] & status_next[i2cm_pkg::SR_MIF];
        result.bus_action = act;
        result.bus_byte   = byte_out;
        result.misuse     = bad;
    end

    // register state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            status_reg   <= i2cm_pkg::STATUS_RESET;
            freq_reg     <= '0;
            filter_reg   <= '0;
            rxbuf_reg    <= '0;
            bufvalid_reg <= 1'b0;
            open_reg     <= 1'b0;
        end
        else if (fire)
        begin
            control_reg  <= control_next;
            status_reg   <= status_next;
            freq_reg     <= freq_next;
            filter_reg   <= filter_next;
            rxbuf_reg    <= rxbuf_next;
            bufvalid_reg <= bufvalid_next;
            open_reg     <= open_next;
        end
    end

endmodule

@@ hdl/i2c_master_register_interface.sv @@
// i2c_master_register_interface: top level, input and result registers around i2cm_regs
// depends on i2cm_pkg, i2cm_stream_if and i2cm_regs
//
// Usage:
//   in_ch carries one register access per item (command, offset, write data)
//   together with the bus side's answers (address acknowledge, received byte).
//   out_ch carries one result item per access: read data, interrupt level,
//   the bus action taken, the byte sent and a misuse flag.
//   An item accepted on in_ch sits in the input register while the access
//   logic runs against the register state, and the result then lands in the
//   output register, which drives out_ch valid.
//   Throughput is one item per cycle while out_ch does not stall; the register
//   state is read and written in the same cycle, so consecutive accesses follow each other directly.
//   When out_ch stalls, the pending result holds and one more accepted item
//   waits in the input register; in_ch ready then drops until out_ch moves.
//   Reset clears both stages and puts the registers at their reset values
//   (status 0x81, all else zero).
module i2c_master_register_interface (
    input  logic         clk,
    input  logic         rst_n,
    i2cm_stream_if.sink   in_ch,
    i2cm_stream_if.source out_ch
);

    i2cm_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    i2cm_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;
    i2cm_pkg::out_item_t result;
    logic                advance;

    // item moves from input stage to result stage
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg <= in_ch.payload;
        end
    end

    // register file and access logic
    i2cm_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

@@ hdl/i2cm_checker.sv @@
// i2cm_checker: port-level checks on the result channel, bound to the top level
// depends on i2cm_pkg and i2c_master_register_interface
module i2cm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input i2cm_pkg::out_item_t out_item
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("result payload changed while stalled");

    // bus byte only carries data on address or send actions
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.bus_action != i2cm_pkg::ACT_ADDR &&
        out_item.bus_action != i2cm_pkg::ACT_SEND |-> out_item.bus_byte == 8'h00)
        else $error("bus byte set without a send");

    // a misused access never drives the bus
    a_misuse_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.misuse |-> out_item.bus_action == i2cm_pkg::ACT_NONE)
        else $error("bus action on a misused access");

    // action code within the defined set
    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.bus_action <= i2cm_pkg::ACT_RECV)
        else $error("undefined bus action");

endmodule

bind i2c_master_register_interface i2cm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
);

@@ verif/i2c_master_register_interface_tb.sv @@
`timescale 1ns / 1ps
// i2c_master_register_interface_tb: self-checking bench for the i2c master register file
// depends on i2cm_pkg, i2cm_stream_if and i2c_master_register_interface
module i2c_master_register_interface_tb;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned RANDOM_ACCESSES = 450;
    localparam int unsigned MAX_WAIT        = 13;
    localparam int unsigned LONG_HOLD       = 60;

    localparam logic [7:0] MEN_BIT  = 8'h01 << i2cm_pkg::CR_MEN;
    localparam logic [7:0] MIEN_BIT = 8'h01 << i2cm_pkg::CR_MIEN;
    localparam logic [7:0] MSTA_BIT = 8'h01 << i2cm_pkg::CR_MSTA;
    localparam logic [7:0] MTX_BIT  = 8'h01 << i2cm_pkg::CR_MTX;
    localparam logic [7:0] RSTA_BIT = 8'h01 << i2cm_pkg::CR_RSTA;

    logic clk;
    logic rst_n;

    i2cm_stream_if #(.payload_t(i2cm_pkg::in_item_t))  in_ch ();
    i2cm_stream_if #(.payload_t(i2cm_pkg::out_item_t)) out_ch ();

    i2c_master_register_interface dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predicted register state
    logic [7:0] pred_ctrl        = 8'h00;
    logic [7:0] pred_status      = i2cm_pkg::STATUS_RESET;
    logic [5:0] pred_freq        = 6'h00;
    logic [5:0] pred_filter      = 6'h00;
    logic [7:0] pred_rxbuf       = 8'h00;
    logic       pred_rxbuf_valid = 1'b0;
    logic       pred_xfer_open   = 1'b0;

    i2cm_pkg::out_item_t pending_results[$];
    int unsigned mismatches           = 0;
    int unsigned accesses_sent        = 0;
    int unsigned cycle_count          = 0;
    bit          sender_quiet         = 1'b0;
    bit          receiver_quiet       = 1'b0;
    int unsigned receiver_hold_cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic rand_bit();
        logic [31:0] r;
        r = $urandom;
        return r[0];
    endfunction

    // a byte went over the bus: interrupt flag up, acknowledge bit down
    function automatic void note_byte_done();
        pred_status[i2cm_pkg::SR_MIF]  = 1'b1;
        pred_status[i2cm_pkg::SR_RXAK] = 1'b0;
    endfunction

    // updates the predicted registers and returns the expected result of one access
    function automatic i2cm_pkg::out_item_t predict_access(input i2cm_pkg::in_item_t acc);
        i2cm_pkg::out_item_t res;
        logic                msta_was;
        logic                busy;
        res      = '0;
        busy     = pred_ctrl[i2cm_pkg::CR_MEN] && pred_status[i2cm_pkg::SR_MBB];
        msta_was = pred_ctrl[i2cm_pkg::CR_MSTA];
        if (acc.command == i2cm_pkg::CMD_WRITE)
        begin
            case (acc.reg_offset)
                i2cm_pkg::OFF_FREQ: pred_freq = acc.write_data[5:0];
                i2cm_pkg::OFF_CTRL:
                begin
                    // start, stop and repeated start all close the transfer
                    if (acc.write_data[i2cm_pkg::CR_MEN] &&
                        ((msta_was != acc.write_data[i2cm_pkg::CR_MSTA]) ||
                         (msta_was && acc.write_data[i2cm_pkg::CR_RSTA])))
                    begin
                        pred_status[i2cm_pkg::SR_MBB] = acc.write_data[i2cm_pkg::CR_MSTA];
                        res.bus_action = i2cm_pkg::ACT_END;
                        pred_xfer_open = 1'b0;
                    end
                    pred_ctrl = acc.write_data & i2cm_pkg::CTRL_WR_MASK;
                end
                i2cm_pkg::OFF_STAT:
                    pred_status = (pred_status & ~i2cm_pkg::STAT_WR_MASK) |
                                  (acc.write_data & i2cm_pkg::STAT_WR_MASK);
                i2cm_pkg::OFF_DATA:
                begin
                    if (!busy)
                        res.misuse = 1'b1;
                    else if (!pred_xfer_open)
                    begin
                        // address phase, transfer opens only on acknowledge
                        res.bus_action = i2cm_pkg::ACT_ADDR;
                        res.bus_byte   = acc.write_data;
                        pred_xfer_open = acc.bus_ack;
                        note_byte_done();
                    end
                    else if (pred_ctrl[i2cm_pkg::CR_MTX])
                    begin
                        res.bus_action = i2cm_pkg::ACT_SEND;
                        res.bus_byte   = acc.write_data;
                        note_byte_done();
                    end
                    else
                        res.misuse = 1'b1;
                end
                i2cm_pkg::OFF_FILT: pred_filter = acc.write_data[5:0];
                default: ;
            endcase
        end
        else
        begin
            case (acc.reg_offset)
                i2cm_pkg::OFF_ADDR: res.read_data = 8'h00;
                i2cm_pkg::OFF_FREQ: res.read_data = {2'b00, pred_freq};
                i2cm_pkg::OFF_CTRL: res.read_data = pred_ctrl & i2cm_pkg::CTRL_RD_MASK;
                i2cm_pkg::OFF_STAT: res.read_data = pred_status;
                i2cm_pkg::OFF_DATA:
                begin
                    // pipelined receive: hand back the old buffer, fetch the next byte
                    res.read_data = pred_rxbuf;
                    if (busy && pred_xfer_open && !pred_ctrl[i2cm_pkg::CR_MTX])
                    begin
                        res.bus_action   = i2cm_pkg::ACT_RECV;
                        pred_rxbuf       = acc.bus_rx_byte;
                        pred_rxbuf_valid = 1'b1;
                        note_byte_done();
                    end
                    else
                    begin
                        res.misuse       = !busy || !pred_rxbuf_valid;
                        pred_rxbuf       = i2cm_pkg::BUF_EMPTY;
                        pred_rxbuf_valid = 1'b0;
                    end
                end
                i2cm_pkg::OFF_FILT: res.read_data = {2'b00, pred_filter};
                default:            res.read_data = i2cm_pkg::RD_UNKNOWN;
            endcase
        end
        res.irq = pred_ctrl[i2cm_pkg::CR_MIEN] & pred_status[i2cm_pkg::SR_MIF];
        return res;
    endfunction

    // compare one accepted result against the oldest prediction
    task automatic check_result(input i2cm_pkg::out_item_t got);
        i2cm_pkg::out_item_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: read_data %02h bus_action %0d", got.read_data,
                   got.bus_action);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
                mismatches++;
            end
            if (got.irq !== want.irq)
            begin
                $error("irq: expected %0b, actual %0b", want.irq, got.irq);
                mismatches++;
            end
            if (got.bus_action !== want.bus_action)
            begin
                $error("bus_action: expected %0d, actual %0d", want.bus_action, got.bus_action);
                mismatches++;
            end
            if (got.bus_byte !== want.bus_byte)
            begin
                $error("bus_byte: expected %02h, actual %02h", want.bus_byte, got.bus_byte);
                mismatches++;
            end
            if (got.misuse !== want.misuse)
            begin
                $error("misuse: expected %0b, actual %0b", want.misuse, got.misuse);
                mismatches++;
            end
        end
    endtask

    // result side: random stalls, optional long hold
    initial
    begin : result_sink
        int unsigned stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (receiver_hold_cycles != 0)
            begin
                stall                = receiver_hold_cycles;
                receiver_hold_cycles = 0;
            end
            else
                stall = receiver_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            check_result(out_ch.payload);
        end
    end

    // offer one access; valid stays up afterwards so a back-to-back item follows cleanly
    task automatic issue_access(input i2cm_pkg::in_item_t acc);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= acc;
        do @(posedge clk); while (!in_ch.ready);
        pending_results.push_back(predict_access(acc));
        accesses_sent++;
    endtask

    task automatic reg_write(input logic [4:0] offset, input logic [7:0] data, input logic ack);
        i2cm_pkg::in_item_t acc;
        acc.command     = i2cm_pkg::CMD_WRITE;
        acc.reg_offset  = offset;
        acc.write_data  = data;
        acc.bus_ack     = ack;
        acc.bus_rx_byte = rand_byte();
        issue_access(acc);
    endtask

    task automatic reg_read(input logic [4:0] offset, input logic [7:0] rx);
        i2cm_pkg::in_item_t acc;
        acc.command     = i2cm_pkg::CMD_READ;
        acc.reg_offset  = offset;
        acc.write_data  = rand_byte();
        acc.bus_ack     = rand_bit();
        acc.bus_rx_byte = rx;
        issue_access(acc);
    endtask

    // fully random access, biased towards the decoded offsets
    function automatic i2cm_pkg::in_item_t random_access();
        i2cm_pkg::in_item_t acc;
        logic [31:0]        r;
        r               = $urandom;
        acc.command     = r[0];
        acc.write_data  = r[31:24];
        acc.bus_ack     = r[11];
        acc.bus_rx_byte = r[23:16];
        if (r[2:1] == 2'd0)
            acc.reg_offset = r[7:3];
        else
            case (r[10:8])
                3'd0:    acc.reg_offset = i2cm_pkg::OFF_ADDR;
                3'd1:    acc.reg_offset = i2cm_pkg::OFF_FREQ;
                3'd2:    acc.reg_offset = i2cm_pkg::OFF_CTRL;
                3'd3:    acc.reg_offset = i2cm_pkg::OFF_STAT;
                3'd4:    acc.reg_offset = i2cm_pkg::OFF_FILT;
                default: acc.reg_offset = i2cm_pkg::OFF_DATA;
            endcase
        return acc;
    endfunction

    // one well-formed bus transfer with random content
    task automatic run_transfer();
        logic [31:0] r;
        logic [7:0]  mode;
        int unsigned n;
        r    = $urandom;
        mode = MEN_BIT | MSTA_BIT | (r[0] ? MIEN_BIT : 8'h00);
        n    = $urandom_range(1, 6);
        // start, with some stray low bits
        reg_write(i2cm_pkg::OFF_CTRL, mode | (r[15:8] & 8'h0b), rand_bit());
        // address phase, mostly acknowledged
        reg_write(i2cm_pkg::OFF_DATA, r[23:16], r[26:24] != 3'd0);
        if (r[27])
        begin
            reg_write(i2cm_pkg::OFF_CTRL, mode | MTX_BIT, rand_bit());
            repeat (n) reg_write(i2cm_pkg::OFF_DATA, rand_byte(), rand_bit());
        end
        else
        begin
            reg_write(i2cm_pkg::OFF_CTRL, mode, rand_bit());
            repeat (n) reg_read(i2cm_pkg::OFF_DATA, rand_byte());
        end
        if (r[29])
            reg_read(i2cm_pkg::OFF_STAT, rand_byte());
        if (r[30])
            reg_write(i2cm_pkg::OFF_STAT, rand_byte(), rand_bit());
        // stop, or a repeated start that chains into the next transfer
        if ($urandom_range(0, 3) != 0)
            reg_write(i2cm_pkg::OFF_CTRL, mode & ~MSTA_BIT, rand_bit());
        else
            reg_write(i2cm_pkg::OFF_CTRL, mode | RSTA_BIT, rand_bit());
    endtask

    // plain registers, unknown offsets, status mask, control write with MEN clear
    task automatic test_plain_registers();
        reg_write(i2cm_pkg::OFF_FREQ, 8'hff, 1'b1);
        reg_read(i2cm_pkg::OFF_FREQ, 8'hff);
        reg_write(i2cm_pkg::OFF_FILT, 8'hc0, 1'b0);
        reg_read(i2cm_pkg::OFF_FILT, 8'h00);
        reg_write(i2cm_pkg::OFF_ADDR, 8'hff, 1'b1);
        reg_read(i2cm_pkg::OFF_ADDR, 8'hff);
        reg_read(5'd31, 8'h00);
        reg_write(5'd31, 8'hff, 1'b1);
        reg_write(i2cm_pkg::OFF_STAT, 8'hff, 1'b0);
        reg_read(i2cm_pkg::OFF_STAT, 8'h00);
        reg_write(i2cm_pkg::OFF_CTRL, 8'h5b, 1'b1);
        reg_read(i2cm_pkg::OFF_CTRL, 8'hff);
    endtask

    // bus events, address with and without acknowledge, send, receive, misuse
    task automatic test_bus_cycle();
        reg_read(i2cm_pkg::OFF_DATA, 8'h5a);
        reg_write(i2cm_pkg::OFF_DATA, 8'h55, 1'b1);
        reg_write(i2cm_pkg::OFF_CTRL, MEN_BIT | MIEN_BIT | MSTA_BIT, 1'b0);
        reg_write(i2cm_pkg::OFF_DATA, 8'ha1, 1'b0);
        reg_write(i2cm_pkg::OFF_DATA, 8'ha0, 1'b1);
        reg_read(i2cm_pkg::OFF_DATA, 8'h00);
        reg_read(i2cm_pkg::OFF_DATA, 8'hff);
        reg_write(i2cm_pkg::OFF_DATA, 8'h33, 1'b1);
        reg_write(i2cm_pkg::OFF_CTRL, MEN_BIT | MIEN_BIT | MSTA_BIT | MTX_BIT, 1'b0);
        reg_write(i2cm_pkg::OFF_DATA, 8'h00, 1'b0);
        reg_write(i2cm_pkg::OFF_DATA, 8'hff, 1'b1);
        reg_read(i2cm_pkg::OFF_DATA, 8'h11);
        reg_read(i2cm_pkg::OFF_DATA, 8'h22);
        reg_write(i2cm_pkg::OFF_STAT, 8'h00, 1'b0);
        reg_write(i2cm_pkg::OFF_CTRL, MEN_BIT | MIEN_BIT | MSTA_BIT | RSTA_BIT, 1'b1);
        reg_write(i2cm_pkg::OFF_CTRL, MEN_BIT, 1'b0);
    endtask

    // long result stall while items keep coming, so the input side backs up
    task automatic test_backpressure();
        sender_quiet         = 1'b1;
        receiver_hold_cycles = LONG_HOLD;
        repeat (16) issue_access(random_access());
        sender_quiet = 1'b0;
    endtask

    // mostly well-formed transfers, some noise, with quiet stretches on both sides
    task automatic test_random_traffic();
        int unsigned target;
        target = accesses_sent + RANDOM_ACCESSES;
        while (accesses_sent < target)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                sender_quiet   = ($urandom_range(0, 2) == 0);
                receiver_quiet = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 3) != 0)
                run_transfer();
            else
                repeat ($urandom_range(1, 4)) issue_access(random_access());
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // main sequence
    initial
    begin : test_sequence
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_registers();
        test_bus_cycle();
        test_backpressure();
        test_random_traffic();
        in_ch.valid <= 1'b0;
        // drain, then watch for stray results
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
